/* hw/rtl/ksm_pkg.sv */
// ----------------------------------------------------------------------------
// ksm_pkg
// Shared constants and control/status types of the KMP stream matcher.
// ----------------------------------------------------------------------------
package ksm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int SYM_W       = 8;
    localparam int FUNC_W      = 2;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

    localparam logic [FUNC_W-1:0] FUNC_PAT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TXT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_END = 2'd2;

    typedef struct packed {
        logic accept;
        logic step;
        logic tail_rd;
        logic tail_ld;
    } t_cmd;

    typedef struct packed {
        logic walk;
        logic mismatch;
        logic full;
        logic is_text;
        logic out_hold;
    } t_sts;

endpackage

/* hw/rtl/ksm_if.sv */
// ----------------------------------------------------------------------------
// ksm_in_if / ksm_out_if
// Valid/ready channels for input requests and match results.
// ----------------------------------------------------------------------------
interface ksm_in_if import ksm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [SYM_W-1:0]  symbol;
    logic              restart;

    modport source (output valid, output func, output symbol, output restart, input ready);
    modport sink   (input valid, input func, input symbol, input restart, output ready);
endinterface

interface ksm_out_if;
    logic valid;
    logic ready;
    logic found;
    logic pattern_overflow;

    modport source (output valid, output found, output pattern_overflow, input ready);
    modport sink   (input valid, input found, input pattern_overflow, output ready);
endinterface

/* hw/rtl/ksm_dp.sv */
// ----------------------------------------------------------------------------
// ksm_dp
// Datapath: pattern and prefix memories, match state and result register.
// ----------------------------------------------------------------------------
module ksm_dp import ksm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic              i_restart,
    input  logic              i_out_ready,
    output t_sts              o_sts,
    output logic              o_out_valid,
    output logic              o_found,
    output logic              o_ovf
);

    logic [SYM_W-1:0] mem_p [MAX_PATTERN];
    logic [IDX_W-1:0] mem_f [MAX_PATTERN];

    logic [LEN_W-1:0] r_len;
    logic [IDX_W-1:0] r_bp;
    logic [IDX_W-1:0] r_match;
    logic             r_found;
    logic             r_seen;
    logic             r_ovf;
    logic [IDX_W-1:0] r_j;
    logic [SYM_W-1:0] r_sym;
    logic             r_is_text;
    logic             r_out_valid;
    logic             r_out_found;
    logic             r_out_ovf;
    logic [SYM_W-1:0] r_pd;
    logic [IDX_W-1:0] r_fd;

    logic             sym_eq;
    logic [LEN_W-1:0] j_inc;
    logic [LEN_W-1:0] len_eff;
    logic             is_pat;
    logic             first_sym;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [SYM_W-1:0] wdata_p;
    logic [IDX_W-1:0] wdata_f;
    logic [IDX_W-1:0] raddr_p;
    logic [IDX_W-1:0] raddr_f;

    assign sym_eq    = (r_sym == r_pd);
    assign j_inc     = {1'b0, r_j} + LEN_W'(sym_eq);
    assign is_pat    = (i_func == FUNC_PAT);
    assign len_eff   = i_restart ? '0 : r_len;
    assign first_sym = is_pat && (len_eff == '0);

    assign o_sts.walk     = (is_pat && (len_eff != '0) && (len_eff < LEN_W'(MAX_PATTERN)))
                         || ((i_func == FUNC_TXT) && !r_ovf && (r_len != '0) && !r_found);
    assign o_sts.mismatch = (r_j != '0) && !sym_eq;
    assign o_sts.full     = (j_inc >= r_len);
    assign o_sts.is_text  = r_is_text;
    assign o_sts.out_hold = r_out_valid && !i_out_ready;

    assign we      = (i_cmd.accept && first_sym)
                  || (i_cmd.step && !o_sts.mismatch && !r_is_text);
    assign waddr   = i_cmd.accept ? '0 : r_len[IDX_W-1:0];
    assign wdata_p = i_cmd.accept ? i_symbol : r_sym;
    assign wdata_f = i_cmd.accept ? '0 : j_inc[IDX_W-1:0];
    assign raddr_p = r_j;
    assign raddr_f = i_cmd.tail_rd ? IDX_W'(r_len - LEN_W'(1)) : IDX_W'(r_j - IDX_W'(1));

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_p[waddr] <= wdata_p;
            mem_f[waddr] <= wdata_f;
        end
        r_pd <= mem_p[raddr_p];
        r_fd <= mem_f[raddr_f];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_bp        <= '0;
            r_match     <= '0;
            r_found     <= 1'b0;
            r_seen      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept && (i_func == FUNC_END)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.accept) begin
                unique case (i_func)
                    FUNC_PAT: begin
                        r_match <= '0;
                        r_found <= 1'b0;
                        r_seen  <= 1'b0;
                        if (len_eff >= LEN_W'(MAX_PATTERN)) begin
                            r_ovf <= 1'b1;
                        end else if (len_eff == '0) begin
                            r_ovf <= 1'b0;
                            r_bp  <= '0;
                            r_len <= LEN_W'(1);
                        end
                    end
                    FUNC_TXT: begin
                        r_seen <= 1'b1;
                    end
                    FUNC_END: begin
                        r_match <= '0;
                        r_found <= 1'b0;
                        r_seen  <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.step && !o_sts.mismatch) begin
                if (!r_is_text) begin
                    r_bp  <= j_inc[IDX_W-1:0];
                    r_len <= r_len + LEN_W'(1);
                end else if (o_sts.full) begin
                    r_found <= 1'b1;
                end else begin
                    r_match <= j_inc[IDX_W-1:0];
                end
            end
            if (i_cmd.tail_ld) begin
                r_match <= r_fd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sym     <= i_symbol;
            r_is_text <= (i_func == FUNC_TXT);
            r_j       <= (i_func == FUNC_TXT) ? r_match : r_bp;
            r_out_ovf <= r_ovf;
            r_out_found <= !r_ovf && ((r_len == '0) ? r_seen : r_found);
        end else if (i_cmd.step && o_sts.mismatch) begin
            r_j <= r_fd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_ovf       = r_out_ovf;

endmodule

/* hw/rtl/ksm_ctrl.sv */
// ----------------------------------------------------------------------------
// ksm_ctrl
// Controller: request handshake and sequencing of the prefix-table walk.
// ----------------------------------------------------------------------------
module ksm_ctrl import ksm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output logic o_ready,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_CMP  = 5'b00100,
        ST_TRD  = 5'b01000,
        ST_TLD  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_ready = (r_state == ST_IDLE) && !i_sts.out_hold;
    assign accept  = i_valid && o_ready;

    assign o_cmd.accept  = accept;
    assign o_cmd.step    = (r_state == ST_CMP);
    assign o_cmd.tail_rd = (r_state == ST_TRD);
    assign o_cmd.tail_ld = (r_state == ST_TLD);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_sts.walk) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                priority if (i_sts.mismatch) begin
                    n_state = ST_READ;
                end else if (i_sts.is_text && i_sts.full) begin
                    n_state = ST_TRD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_TRD: begin
                n_state = ST_TLD;
            end
            ST_TLD: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/kmp_stream_matcher_core.sv */
// ----------------------------------------------------------------------------
// kmp_stream_matcher_core
// Knuth-Morris-Pratt matcher over a symbol stream with incremental table build.
//
//   channel  dir  payload                    moves
//   i_in     in   func, symbol, restart      one request per handshake
//   o_out    out  found, pattern_overflow    one result per end of text
//
// End of text, dropped and trivial requests are done in ST_IDLE, where they are accepted.
// A pattern or text symbol that walks the table steps through ST_READ and ST_CMP,
// again for each fallback, then ST_TRD and ST_TLD when a text symbol completes
// a match; each of the pattern and prefix memories has a single read port.
// Reset clears the controller state, pattern length, match state and output valid; the memories are not cleared.
// A pending result holds i_in.ready low until o_out accepts it.
// ----------------------------------------------------------------------------
module kmp_stream_matcher_core import ksm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ksm_in_if.sink      i_in,
    ksm_out_if.source   o_out
);

    t_cmd cmd;
    t_sts sts;
    logic ready;

    ksm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_sts   (sts),
        .o_ready (ready),
        .o_cmd   (cmd)
    );

    ksm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_func      (i_in.func),
        .i_symbol    (i_in.symbol),
        .i_restart   (i_in.restart),
        .i_out_ready (o_out.ready),
        .o_sts       (sts),
        .o_out_valid (o_out.valid),
        .o_found     (o_out.found),
        .o_ovf       (o_out.pattern_overflow)
    );

    assign i_in.ready = ready;

endmodule

/* dv/kmp_stream_matcher_core_test.sv */
// ----------------------------------------------------------------------------
// kmp_stream_matcher_core_test
// Self-checking bench for the KMP stream matcher. Pattern, text, end-of-text
// and unused requests are driven on i_in. A scoreboard tracks its own pattern
// store and prefix table and predicts one verdict per end of text. Each result
// on o_out is checked against the oldest prediction. A short directed opening
// is followed by random patterns, texts and noise over several idle/stall
// phases.
// ----------------------------------------------------------------------------
module kmp_stream_matcher_core_test;
    import ksm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
    localparam int ITEM_TARGET   = 1150;
    localparam int SEGMENTS      = 8;
    localparam int SETTLE_CYCLES = 160;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic found;
        logic overflow;
    } t_verdict;

    class kmp_verdict_board;
        logic [SYM_W-1:0] pat_mem [MAX_PATTERN];
        logic [IDX_W-1:0] lps [MAX_PATTERN];
        logic [LEN_W-1:0] pat_len;
        logic [IDX_W-1:0] build_len;
        logic [LEN_W-1:0] matched;
        logic             found_flag;
        logic             text_seen;
        logic             overflow_flag;
        t_verdict         expected_verdicts [$];
        int               mismatches;
        int               requests;
        int               verdicts;
        int               hits;
        int               overflows;

        function new();
            foreach (pat_mem[k]) begin
                pat_mem[k] = '0;
                lps[k]     = '0;
            end
            pat_len       = '0;
            build_len     = '0;
            matched       = '0;
            found_flag    = 1'b0;
            text_seen     = 1'b0;
            overflow_flag = 1'b0;
            mismatches    = 0;
            requests      = 0;
            verdicts      = 0;
            hits          = 0;
            overflows     = 0;
        endfunction

        function void clear_text();
            matched    = '0;
            found_flag = 1'b0;
            text_seen  = 1'b0;
        endfunction

        function void absorb_pattern_symbol(logic [SYM_W-1:0] sym, logic restart);
            int k;
            clear_text();
            if (restart) begin
                pat_len       = '0;
                build_len     = '0;
                overflow_flag = 1'b0;
            end
            if (pat_len == LEN_W'(MAX_PATTERN)) begin
                overflow_flag = 1'b1;
                return;
            end
            pat_mem[pat_len] = sym;
            if (pat_len == '0) begin
                lps[0]    = '0;
                build_len = '0;
            end else begin
                k = int'(build_len);
                while (k > 0 && sym != pat_mem[k])
                    k = int'(lps[k-1]);
                if (sym == pat_mem[k])
                    k++;
                lps[pat_len] = IDX_W'(k);
                build_len    = IDX_W'(k);
            end
            pat_len++;
        endfunction

        function void scan_text_symbol(logic [SYM_W-1:0] sym);
            int j;
            text_seen = 1'b1;
            if (overflow_flag || pat_len == '0 || found_flag)
                return;
            j = int'(matched);
            while (j > 0 && sym != pat_mem[j])
                j = int'(lps[j-1]);
            if (sym == pat_mem[j])
                j++;
            if (j >= int'(pat_len)) begin
                found_flag = 1'b1;
                j = int'(lps[pat_len-1]);
            end
            matched = LEN_W'(j);
        endfunction

        function void note_request(logic [FUNC_W-1:0] func, logic [SYM_W-1:0] sym,
                                   logic restart);
            t_verdict v;
            requests++;
            case (func)
                FUNC_PAT: absorb_pattern_symbol(sym, restart);
                FUNC_TXT: scan_text_symbol(sym);
                FUNC_END: begin
                    v.overflow = overflow_flag;
                    if (overflow_flag)
                        v.found = 1'b0;
                    else if (pat_len == '0)
                        v.found = text_seen;
                    else
                        v.found = found_flag;
                    expected_verdicts.push_back(v);
                    clear_text();
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic found, logic overflow);
            t_verdict want;
            verdicts++;
            hits      += int'(found);
            overflows += int'(overflow);
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected result found=%0b overflow=%0b",
                             $realtime, found, overflow);
                return;
            end
            want = expected_verdicts.pop_front();
            if (found !== want.found || overflow !== want.overflow) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"%0t: result %0d mismatch: found exp %0b got %0b, ",
                              "overflow exp %0b got %0b"},
                             $realtime, verdicts, want.found, found, want.overflow, overflow);
            end
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ksm_in_if  in_if ();
    ksm_out_if out_if ();

    kmp_stream_matcher_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    kmp_verdict_board board;
    int               sender_idle_pct;
    int               receiver_stall_pct;
    int               items_sent;
    int               cycle_count;
    logic [SYM_W-1:0] alphabet [3];
    int               alphabet_n;
    logic [SYM_W-1:0] cur_pattern [$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES) begin
                $display("timeout after %0d cycles, %0d results pending",
                         cycle_count, board.pending());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready = ($urandom_range(99) >= receiver_stall_pct);
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready)
                board.check_result(out_if.found, out_if.pattern_overflow);
        end
    end

    task automatic send_request(logic [FUNC_W-1:0] func, logic [SYM_W-1:0] sym,
                                logic restart);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   = 1'b1;
        in_if.func    = func;
        in_if.symbol  = sym;
        in_if.restart = restart;
        do
            @(posedge i_clk);
        while (!in_if.ready);
        board.note_request(func, sym, restart);
        if (func != FUNC_NONE)
            items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_if.valid = 1'b0;
        while (board.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [SYM_W-1:0] pick_symbol();
        if ($urandom_range(9) == 0)
            return SYM_W'($urandom_range(255));
        return alphabet[$urandom_range(alphabet_n - 1)];
    endfunction

    task automatic send_text_and_end();
        int len;
        int at;
        bit embed;
        len   = $urandom_range(24);
        embed = 1'($urandom_range(1));
        at    = $urandom_range(len);
        for (int i = 0; i < len; i++) begin
            if (embed && i >= at && i - at < cur_pattern.size())
                send_request(FUNC_TXT, cur_pattern[i-at], 1'b0);
            else
                send_request(FUNC_TXT, pick_symbol(), 1'b0);
        end
        send_request(FUNC_END, SYM_W'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    initial begin
        int base;
        int seg_end;
        int pick;
        int len;
        int phase_order [SEGMENTS];

        phase_order = '{0, 1, 2, 3, 1, 2, 3, 0};
        board              = new();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        items_sent         = 0;
        in_if.valid        = 1'b0;
        in_if.func         = FUNC_END;
        in_if.symbol       = '0;
        in_if.restart      = 1'b0;
        i_rst_n            = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty pattern: empty text, then non-empty text
        send_request(FUNC_END,  8'h00, 1'b0);
        send_request(FUNC_TXT,  8'h00, 1'b0);
        send_request(FUNC_END,  8'hFF, 1'b1);
        send_request(FUNC_NONE, 8'hFF, 1'b1);
        send_request(FUNC_END,  8'h00, 1'b0);
        // pattern FF 00 FF, occurrence found after a fallback
        send_request(FUNC_PAT,  8'hFF, 1'b1);
        send_request(FUNC_PAT,  8'h00, 1'b0);
        send_request(FUNC_PAT,  8'hFF, 1'b0);
        send_request(FUNC_TXT,  8'hFF, 1'b0);
        send_request(FUNC_TXT,  8'hFF, 1'b0);
        send_request(FUNC_TXT,  8'h00, 1'b0);
        send_request(FUNC_TXT,  8'hFF, 1'b0);
        send_request(FUNC_TXT,  8'h5A, 1'b0);
        send_request(FUNC_END,  8'h00, 1'b0);
        // pattern symbol mid-text clears the partial match
        send_request(FUNC_TXT,  8'hFF, 1'b0);
        send_request(FUNC_TXT,  8'h00, 1'b0);
        send_request(FUNC_PAT,  8'h00, 1'b0);
        send_request(FUNC_TXT,  8'hFF, 1'b0);
        send_request(FUNC_END,  8'h00, 1'b0);
        // text after a hit, then a miss
        send_request(FUNC_TXT,  8'hFF, 1'b0);
        send_request(FUNC_TXT,  8'h00, 1'b0);
        send_request(FUNC_TXT,  8'hFF, 1'b0);
        send_request(FUNC_TXT,  8'h00, 1'b0);
        send_request(FUNC_TXT,  8'hA5, 1'b0);
        send_request(FUNC_END,  8'h00, 1'b0);
        send_request(FUNC_TXT,  8'hFF, 1'b0);
        send_request(FUNC_END,  8'h00, 1'b0);
        drain_results();

        cur_pattern = '{8'hFF, 8'h00, 8'hFF, 8'h00};
        alphabet    = '{8'hFF, 8'h00, 8'h00};
        alphabet_n  = 2;
        base        = items_sent;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (phase_order[seg])
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
                default: begin sender_idle_pct = 32; receiver_stall_pct = 32; end
            endcase
            seg_end = base + (seg + 1) * (ITEM_TARGET - base) / SEGMENTS;
            while (items_sent < seg_end) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    alphabet_n = $urandom_range(1, 3);
                    foreach (alphabet[k])
                        alphabet[k] = SYM_W'($urandom_range(255));
                    pick = $urandom_range(99);
                    if (pick < 3)
                        len = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 6);
                    else if (pick < 8)
                        len = $urandom_range(40, MAX_PATTERN);
                    else
                        len = $urandom_range(1, 6);
                    cur_pattern.delete();
                    for (int i = 0; i < len; i++) begin
                        cur_pattern.push_back(pick_symbol());
                        send_request(FUNC_PAT, cur_pattern[i], i == 0);
                    end
                    repeat ($urandom_range(1, 4)) send_text_and_end();
                end else if (pick < 80) begin
                    repeat ($urandom_range(1, 3)) begin
                        cur_pattern.push_back(pick_symbol());
                        send_request(FUNC_PAT, cur_pattern[$], 1'b0);
                    end
                    send_text_and_end();
                end else begin
                    repeat ($urandom_range(1, 8))
                        send_request(FUNC_W'($urandom_range(3)),
                                     SYM_W'($urandom_range(255)),
                                     $urandom_range(3) == 0);
                end
            end
            drain_results();
        end

        drain_results();
        board.mismatches += board.pending();
        $display("ran %0d requests over %0d cycles: %0d verdicts, %0d found, %0d overflow",
                 board.requests, cycle_count, board.verdicts, board.hits, board.overflows);
        $display("idle phases: none, sender 47%%, receiver 47%%, both 32%%; mismatches %0d",
                 board.mismatches);
        if (board.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
